>>> src/eia_pkg.sv
// ----------------------------------------------------------------------------
// eia_pkg
// Shared types and constants of the extended integer ALU: operand tags,
// operation codes, back-end unit selection and the queue control word.
// ----------------------------------------------------------------------------
package eia_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int KIND_W          = 2;
	localparam int OP_W            = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_FIN   = 2'd0,
		KIND_PINF  = 2'd1,
		KIND_NINF  = 2'd2,
		KIND_UNDEF = 2'd3
	} kind_t;

	typedef enum logic [OP_W-1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// which back-end unit produces the finite value; SEL_ZERO gives value 0
	typedef enum logic [1:0] {
		SEL_ZERO = 2'd0,
		SEL_ADD  = 2'd1,
		SEL_MUL  = 2'd2,
		SEL_DIV  = 2'd3
	} sel_t;

	typedef struct packed {
		kind_t kind;
		sel_t  sel;
		logic  neg;
	} ctl_t;

	localparam int CTL_W = $bits(ctl_t);

endpackage

>>> src/eia_front.sv
// ----------------------------------------------------------------------------
// eia_front
// Classify one operation: resolve the tag of the result, choose the back-end
// unit and prepare its operands (negated subtrahend, divide magnitudes).
// ----------------------------------------------------------------------------
module eia_front #(
	parameter int VALUE_WIDTH = eia_pkg::VALUE_WIDTH_DEF
) (
	input  eia_pkg::op_t             op,
	input  eia_pkg::kind_t           a_kind,
	input  logic [VALUE_WIDTH-1:0]   a_value,
	input  eia_pkg::kind_t           b_kind,
	input  logic [VALUE_WIDTH-1:0]   b_value,
	output eia_pkg::ctl_t            ctl,
	output logic [VALUE_WIDTH-1:0]   x,
	output logic [VALUE_WIDTH-1:0]   y
);
	import eia_pkg::*;

	logic  na, nb, za, zb, a_fin, b_fin, sa, sb;
	kind_t bk;

	function automatic kind_t flip_inf(input kind_t k);
		return (k == KIND_PINF) ? KIND_NINF : KIND_PINF;
	endfunction

	always_comb begin
		na    = a_value[VALUE_WIDTH-1];
		nb    = b_value[VALUE_WIDTH-1];
		za    = (a_value == '0);
		zb    = (b_value == '0);
		a_fin = (a_kind == KIND_FIN);
		b_fin = (b_kind == KIND_FIN);
		sa    = a_fin ? na : (a_kind == KIND_NINF);
		sb    = b_fin ? nb : (b_kind == KIND_NINF);
		// subtract: negate the right tag, undefined and finite stay as they are
		bk    = (op == OP_SUB && !b_fin && b_kind != KIND_UNDEF) ? flip_inf(b_kind) : b_kind;
		x     = a_value;
		y     = (op == OP_SUB) ? ('0 - b_value) : b_value;
		ctl   = '{kind: KIND_UNDEF, sel: SEL_ZERO, neg: 1'b0};
		unique case (op)
			OP_ADD, OP_SUB: begin
				priority if (a_kind == KIND_UNDEF || bk == KIND_UNDEF) begin
					ctl.kind = KIND_UNDEF;
				end else if (!a_fin && bk != KIND_FIN) begin
					ctl.kind = (a_kind == bk) ? a_kind : KIND_UNDEF;
				end else if (!a_fin) begin
					ctl.kind = a_kind;
				end else if (bk != KIND_FIN) begin
					ctl.kind = bk;
				end else begin
					ctl.kind = KIND_FIN;
					ctl.sel  = SEL_ADD;
				end
			end
			OP_MUL: begin
				priority if (a_kind == KIND_UNDEF || b_kind == KIND_UNDEF) begin
					ctl.kind = KIND_UNDEF;
				end else if (a_fin && b_fin) begin
					ctl.kind = KIND_FIN;
					ctl.sel  = SEL_MUL;
				end else if ((a_fin && za) || (b_fin && zb)) begin
					ctl.kind = KIND_UNDEF;
				end else begin
					ctl.kind = (sa != sb) ? KIND_NINF : KIND_PINF;
				end
			end
			OP_DIV: begin
				x       = na ? ('0 - a_value) : a_value;
				y       = nb ? ('0 - b_value) : b_value;
				ctl.neg = na ^ nb;
				priority if (a_kind == KIND_UNDEF || b_kind == KIND_UNDEF) begin
					ctl.kind = KIND_UNDEF;
				end else if (!a_fin) begin
					if (!b_fin) begin
						ctl.kind = KIND_UNDEF;
					end else begin
						ctl.kind = nb ? flip_inf(a_kind) : a_kind;
					end
				end else if (!b_fin) begin
					// finite over infinity: finite zero
					ctl.kind = KIND_FIN;
				end else if (zb) begin
					if (za) begin
						ctl.kind = KIND_UNDEF;
					end else begin
						ctl.kind = na ? KIND_NINF : KIND_PINF;
					end
				end else begin
					ctl.kind = KIND_FIN;
					ctl.sel  = SEL_DIV;
				end
			end
			default: begin
				ctl.kind = KIND_UNDEF;
			end
		endcase
	end

endmodule

>>> src/eia_queue.sv
// ----------------------------------------------------------------------------
// eia_queue
// Short register FIFO between the classifier and the execution pipeline.
// ----------------------------------------------------------------------------
module eia_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = eia_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] rd_data
);
	import eia_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count above depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0) else $error("queue popped while empty");
	a_push_pop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		push && pop |=> $stable(count_q)) else $error("queue count moved on push and pop");

endmodule

>>> src/eia_back.sv
// ----------------------------------------------------------------------------
// eia_back
// Execution pipeline: adder, split multiplier and a one-bit-per-stage
// restoring divider, all at the same latency, ending in the output register.
// ----------------------------------------------------------------------------
module eia_back #(
	parameter int VALUE_WIDTH = eia_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  eia_pkg::ctl_t          in_ctl,
	input  logic [VALUE_WIDTH-1:0] in_x,
	input  logic [VALUE_WIDTH-1:0] in_y,
	output logic                   out_valid,
	input  logic                   out_ready,
	output eia_pkg::kind_t         out_kind,
	output logic [VALUE_WIDTH-1:0] out_value
);
	import eia_pkg::*;

	localparam int VW   = VALUE_WIDTH;
	localparam int LAST = VW + 1;        // stage 1 loads, stages 2..LAST divide
	localparam int H    = (VW + 1) / 2;  // low half of the multiplier split
	localparam int HI   = VW - H;

	logic                en;
	logic [LAST:1]       vld_s;
	ctl_t                ctl_s [LAST:1];
	logic [VW-1:0]       rem_s [LAST:1];
	logic [VW-1:0]       quo_s [LAST:1];
	logic [VW-1:0]       den_s [LAST:1];
	logic [VW-1:0]       pp_ll_s1;
	logic [HI-1:0]       pp_x1_s1, pp_x2_s1;
	logic [2*H-1:0]      ll_full;
	logic [HI+H-1:0]     x1_full, x2_full;
	logic [HI-1:0]       cross_sum;
	logic [VW-1:0]       mul_sum;
	logic [VW+1:0]       diff   [LAST:2];
	logic [VW-1:0]       nxt_rem[LAST:2];
	logic [VW-1:0]       nxt_quo[LAST:2];
	logic                out_valid_q;
	kind_t               out_kind_q;
	logic [VW-1:0]       out_value_q;

	// whole pipeline moves together; it stalls only on a held output
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	assign ll_full   = in_x[H-1:0] * in_y[H-1:0];
	assign x1_full   = in_x[VW-1:H] * in_y[H-1:0];
	assign x2_full   = in_x[H-1:0] * in_y[VW-1:H];
	assign cross_sum = pp_x1_s1 + pp_x2_s1;
	assign mul_sum   = pp_ll_s1 + {cross_sum, {H{1'b0}}};

	always_comb begin
		for (int k = 2; k <= LAST; k++) begin
			diff[k]    = {1'b0, rem_s[k-1], quo_s[k-1][VW-1]} - {2'b00, den_s[k-1]};
			nxt_rem[k] = rem_s[k-1];
			nxt_quo[k] = quo_s[k-1];
			if (ctl_s[k-1].sel == SEL_DIV) begin
				if (!diff[k][VW+1]) begin
					nxt_rem[k] = diff[k][VW-1:0];
					nxt_quo[k] = {quo_s[k-1][VW-2:0], 1'b1};
				end else begin
					nxt_rem[k] = {rem_s[k-1][VW-2:0], quo_s[k-1][VW-1]};
					nxt_quo[k] = {quo_s[k-1][VW-2:0], 1'b0};
				end
			end else if (k == 2 && ctl_s[k-1].sel == SEL_MUL) begin
				nxt_quo[k] = mul_sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s       <= {vld_s[LAST-1:1], in_valid};
			out_valid_q <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s[1]  <= in_ctl;
			rem_s[1]  <= '0;
			den_s[1]  <= in_y;
			quo_s[1]  <= (in_ctl.sel == SEL_ADD) ? in_x + in_y : in_x;
			pp_ll_s1  <= ll_full[VW-1:0];
			pp_x1_s1  <= x1_full[HI-1:0];
			pp_x2_s1  <= x2_full[HI-1:0];
			for (int k = 2; k <= LAST; k++) begin
				ctl_s[k] <= ctl_s[k-1];
				den_s[k] <= den_s[k-1];
				rem_s[k] <= nxt_rem[k];
				quo_s[k] <= nxt_quo[k];
			end
			out_kind_q <= ctl_s[LAST].kind;
			unique case (ctl_s[LAST].sel)
				SEL_ZERO: out_value_q <= '0;
				SEL_DIV:  out_value_q <= ctl_s[LAST].neg ? '0 - quo_s[LAST] : quo_s[LAST];
				default:  out_value_q <= quo_s[LAST];
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_value = out_value_q;

	a_special_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_FIN |-> out_value == '0)
		else $error("special result with nonzero value");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s)) else $error("pipeline moved while stalled");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s[LAST] |=> out_valid) else $error("last stage item lost");

endmodule

>>> src/extended_integer_alu.sv
// ----------------------------------------------------------------------------
// extended_integer_alu
// Add, subtract, multiply and truncating divide on tagged integers that may
// be finite, plus infinity, minus infinity or undefined.
// ----------------------------------------------------------------------------
// One operation is accepted per transfer and gives exactly one result, in
// order. The block takes a new operation every cycle while the output side
// keeps taking results; throughput is one per cycle. The pipeline depth is
// set by the restoring divider, which resolves one quotient bit per pipeline
// stage; add and multiply ride the same stages so results stay in order.
// Finite results wrap to VALUE_WIDTH bits (MIN / -1 gives MIN), and every
// non-finite result carries value zero. The input side stalls only when the
// operation queue is full, the output side holds its register until taken.
module extended_integer_alu #(
	parameter int VALUE_WIDTH = eia_pkg::VALUE_WIDTH_DEF,
	parameter int QUEUE_DEPTH = eia_pkg::QUEUE_DEPTH_DEF,
	localparam int IN_DATA_W  = ((2 * VALUE_WIDTH + 7) / 8) * 8,
	localparam int OUT_DATA_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // a_value, b_value, zero pad
	input  logic [5:0]            s_axis_tuser,   // op[1:0], a_kind[3:2], b_kind[5:4]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // result_value, zero pad
	output logic [1:0]            m_axis_tuser    // result_kind
);
	import eia_pkg::*;

	localparam int VW   = VALUE_WIDTH;
	localparam int QW   = CTL_W + 2 * VW;

	ctl_t           f_ctl, q_ctl;
	logic [VW-1:0]  f_x, f_y, q_x, q_y;
	logic           q_full, q_not_empty, q_pop, b_ready;
	logic [QW-1:0]  q_rd;
	kind_t          r_kind;
	logic [VW-1:0]  r_value;
	logic           accept;

	// transfer into the queue whenever it has room
	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && !q_full;

	// classify the operation and prepare unit operands
	eia_front #(
		.VALUE_WIDTH (VW)
	) u_front (
		.op      (op_t'(s_axis_tuser[1:0])),
		.a_kind  (kind_t'(s_axis_tuser[3:2])),
		.a_value (s_axis_tdata[VW-1:0]),
		.b_kind  (kind_t'(s_axis_tuser[5:4])),
		.b_value (s_axis_tdata[2*VW-1:VW]),
		.ctl     (f_ctl),
		.x       (f_x),
		.y       (f_y)
	);

	// decouple classification from execution
	eia_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.wr_data   ({f_y, f_x, f_ctl}),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_data   (q_rd)
	);

	assign q_ctl = ctl_t'(q_rd[CTL_W-1:0]);
	assign q_x   = q_rd[CTL_W +: VW];
	assign q_y   = q_rd[CTL_W + VW +: VW];
	// advance the queue head into the pipeline when the pipeline moves
	assign q_pop = q_not_empty && b_ready;

	eia_back #(
		.VALUE_WIDTH (VW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_not_empty),
		.in_ready  (b_ready),
		.in_ctl    (q_ctl),
		.in_x      (q_x),
		.in_y      (q_y),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (r_kind),
		.out_value (r_value)
	);

	assign m_axis_tuser = r_kind;
	assign m_axis_tdata = OUT_DATA_W'(r_value);

endmodule

>>> dv/extended_integer_alu_tb.sv
// ----------------------------------------------------------------------------
// extended_integer_alu_tb
// Self-checking bench for the extended integer ALU. A directed list of corner
// cases, then random operations, go through a bursty stream driver; a monitor
// with its own stall pattern compares each result with an in-bench predictor.
// ----------------------------------------------------------------------------
module extended_integer_alu_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import eia_pkg::*;

	localparam int VW          = VALUE_WIDTH_DEF;
	localparam int CLK_PERIOD  = 12;
	localparam int RANDOM_OPS  = 1800;
	localparam int CYCLE_LIMIT = 200000;
	// pipeline depth of the block plus some margin
	localparam int DRAIN_CYCLES = VW + 10;
	// long receiver hold-off: when it starts and how long it lasts
	localparam int HOLD_AFTER  = 400;
	localparam int HOLD_CYCLES = 200;

	localparam logic [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};

	// one operation as offered on the input stream
	typedef struct packed {
		logic          wait_idle;   // hold this one back until all results are in
		op_t           op;
		kind_t         a_kind;
		logic [VW-1:0] a_value;
		kind_t         b_kind;
		logic [VW-1:0] b_value;
	} alu_op_t;

	typedef struct packed {
		kind_t         kind;
		logic [VW-1:0] value;
	} alu_result_t;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_FREE,
		RX_RANDOM,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic          clk           = 1'b0;
	logic          arst_n        = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [63:0]   s_axis_tdata  = '0;   // a_value[31:0], b_value[63:32]
	logic [5:0]    s_axis_tuser  = '0;   // op[1:0], a_kind[3:2], b_kind[5:4]
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [31:0]   m_axis_tdata;         // result_value[31:0]
	logic [1:0]    m_axis_tuser;         // result_kind[1:0]

	alu_op_t       pending_ops[$];       // operations not yet offered
	alu_result_t   expected_results[$];  // predicted results, oldest first

	alu_op_t       drv_op;
	alu_result_t   drv_exp;
	alu_result_t   mon_exp;
	logic          drv_offer;
	int unsigned   burst_left    = 1;
	int unsigned   gap_left      = 0;
	int unsigned   accepted_cnt  = 0;
	int unsigned   error_cnt     = 0;
	int unsigned   cycle_cnt     = 0;
	int unsigned   hold_cnt      = 0;
	logic          hold_off      = 1'b0;
	logic          hold_done     = 1'b0;
	rx_mode_t      rx_mode       = RX_FREE;
	int unsigned   rx_left       = 0;
	int unsigned   rx_phase      = 0;
	logic          rx_ready;

	extended_integer_alu u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor: extended-integer add, subtract, multiply and divide
	// ------------------------------------------------------------------------
	function automatic alu_result_t eval_extended_op(alu_op_t x);
		alu_result_t   r;
		kind_t         ak, bk;
		logic [VW-1:0] av, bv, ma, mb, q;
		logic          na, nb, sa, sb;
		ak = x.a_kind;
		av = x.a_value;
		bk = x.b_kind;
		bv = x.b_value;
		r.kind  = KIND_FIN;
		r.value = '0;
		// subtract is add with b negated: swap the infinities, wrap finite b
		if (x.op == OP_SUB) begin
			if (bk == KIND_PINF)
				bk = KIND_NINF;
			else if (bk == KIND_NINF)
				bk = KIND_PINF;
			else if (bk == KIND_FIN)
				bv = -bv;
		end
		na = av[VW-1];
		nb = bv[VW-1];
		if (ak == KIND_UNDEF || bk == KIND_UNDEF) begin
			r.kind = KIND_UNDEF;
		end else begin
			case (x.op)
			OP_ADD, OP_SUB: begin
				if (ak != KIND_FIN && bk != KIND_FIN)
					r.kind = (ak == bk) ? ak : KIND_UNDEF;
				else if (ak != KIND_FIN)
					r.kind = ak;
				else if (bk != KIND_FIN)
					r.kind = bk;
				else
					r.value = av + bv;
			end
			OP_MUL: begin
				if (ak == KIND_FIN && bk == KIND_FIN) begin
					r.value = av * bv;
				end else if ((ak == KIND_FIN && av == '0) || (bk == KIND_FIN && bv == '0)) begin
					r.kind = KIND_UNDEF;
				end else begin
					sa = (ak == KIND_FIN) ? na : (ak == KIND_NINF);
					sb = (bk == KIND_FIN) ? nb : (bk == KIND_NINF);
					r.kind = (sa != sb) ? KIND_NINF : KIND_PINF;
				end
			end
			default: begin
				if (ak != KIND_FIN) begin
					// infinite numerator: a zero divisor keeps the sign
					if (bk != KIND_FIN)
						r.kind = KIND_UNDEF;
					else if (nb)
						r.kind = (ak == KIND_PINF) ? KIND_NINF : KIND_PINF;
					else
						r.kind = ak;
				end else if (bk != KIND_FIN) begin
					r.value = '0;
				end else if (bv == '0) begin
					if (av == '0)
						r.kind = KIND_UNDEF;
					else
						r.kind = na ? KIND_NINF : KIND_PINF;
				end else begin
					// truncate toward zero on magnitudes; MIN / -1 wraps to MIN
					ma = na ? -av : av;
					mb = nb ? -bv : bv;
					q  = ma / mb;
					r.value = (na != nb) ? -q : q;
				end
			end
			endcase
		end
		if (r.kind != KIND_FIN)
			r.value = '0;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic queue_op(input op_t op, input kind_t ak, input logic [VW-1:0] av,
	                        input kind_t bk, input logic [VW-1:0] bv, input logic wait_idle);
		alu_op_t x;
		x.wait_idle = wait_idle;
		x.op        = op;
		x.a_kind    = ak;
		x.a_value   = av;
		x.b_kind    = bk;
		x.b_value   = bv;
		pending_ops.push_back(x);
	endtask

	// operand values lean on the edges: zero, one, minus one, MIN, MAX, small
	function automatic logic [VW-1:0] rand_value();
		logic [VW-1:0] v;
		case ($urandom_range(0, 11))
		0: v = '0;
		1: v = 1;
		2: v = '1;
		3: v = VAL_MIN;
		4: v = VAL_MAX;
		5, 6: v = $urandom_range(0, 40) - 20;
		default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic kind_t rand_kind();
		kind_t k;
		case ($urandom_range(0, 9))
		0: k = KIND_PINF;
		1: k = KIND_NINF;
		2: k = KIND_UNDEF;
		default: k = KIND_FIN;
		endcase
		return k;
	endfunction

	task automatic report_mismatch(input string what, input logic [VW-1:0] got,
	                               input logic [VW-1:0] want);
		$display("MISMATCH %s: got %h, expected %h", what, got, want);
		error_cnt++;
	endtask

	// ------------------------------------------------------------------------
	// Driver: bursts of random length with random gaps between them
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else begin
			// transfer on the input side: predict its result right away
			if (s_axis_tvalid && s_axis_tready) begin
				drv_exp = eval_extended_op(drv_op);
				expected_results.push_back(drv_exp);
				accepted_cnt++;
			end
			// advance to the next operation once the current one is gone
			if (!s_axis_tvalid || s_axis_tready) begin
				drv_offer = 1'b0;
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_ops.size() != 0 &&
				             !(pending_ops[0].wait_idle && expected_results.size() != 0)) begin
					drv_op    = pending_ops.pop_front();
					drv_offer = 1'b1;
					s_axis_tdata <= {drv_op.b_value, drv_op.a_value};
					s_axis_tuser <= {drv_op.b_kind, drv_op.a_kind, drv_op.op};
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						// now and then a long burst with no gaps at all
						burst_left = ($urandom_range(0, 4) == 0) ? 150 : $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
				s_axis_tvalid <= drv_offer;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Long receiver hold-off: once enough traffic has gone in, hold tready
	// low long enough that the pipeline and its queue fill and the input stalls
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_off  <= 1'b0;
			hold_done <= 1'b0;
			hold_cnt  <= 0;
		end else if (!hold_done && accepted_cnt >= HOLD_AFTER) begin
			if (hold_cnt == HOLD_CYCLES) begin
				hold_off  <= 1'b0;
				hold_done <= 1'b1;
			end else begin
				hold_off <= 1'b1;
				hold_cnt <= hold_cnt + 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check each output transfer, then pick the next tready
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata, '0);
				end else begin
					mon_exp = expected_results.pop_front();
					if (m_axis_tuser !== mon_exp.kind)
						report_mismatch("result_kind", m_axis_tuser, mon_exp.kind);
					if (m_axis_tdata !== mon_exp.value)
						report_mismatch("result_value", m_axis_tdata, mon_exp.value);
				end
			end
			// a new stall pattern is drawn whenever the current one has run out
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 200);
			end else begin
				rx_left--;
			end
			rx_phase++;
			case (rx_mode)
			RX_FREE:     rx_ready = 1'b1;
			RX_RANDOM:   rx_ready = $urandom_range(0, 1);
			RX_SPARSE:   rx_ready = ($urandom_range(0, 3) == 0);
			default:     rx_ready = (rx_phase % 3 == 0);
			endcase
			m_axis_tready <= rx_ready && !hold_off;
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("extended_integer_alu_tb NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of test
	// ------------------------------------------------------------------------
	initial begin
		// directed corner cases, one group per operation
		queue_op(OP_ADD, KIND_FIN,   VAL_MAX,  KIND_FIN,   1,        1'b0);  // wraps to MIN
		queue_op(OP_ADD, KIND_PINF,  $urandom, KIND_NINF,  $urandom, 1'b0);  // opposite infinities
		queue_op(OP_ADD, KIND_NINF,  '0,       KIND_FIN,   VAL_MAX,  1'b0);
		queue_op(OP_ADD, KIND_UNDEF, '0,       KIND_FIN,   5,        1'b0);
		queue_op(OP_ADD, KIND_PINF,  '0,       KIND_PINF,  '0,       1'b0);
		queue_op(OP_SUB, KIND_FIN,   VAL_MIN,  KIND_FIN,   1,        1'b0);  // wraps to MAX
		queue_op(OP_SUB, KIND_FIN,   '0,       KIND_FIN,   VAL_MIN,  1'b0);  // -MIN stays MIN
		queue_op(OP_SUB, KIND_PINF,  '0,       KIND_PINF,  '0,       1'b0);  // undefined
		queue_op(OP_SUB, KIND_FIN,   5,        KIND_NINF,  '1,       1'b0);  // plus infinity
		queue_op(OP_SUB, KIND_FIN,   '1,       KIND_UNDEF, '0,       1'b0);
		queue_op(OP_MUL, KIND_FIN,   VAL_MIN,  KIND_FIN,   '1,       1'b0);  // MIN * -1 = MIN
		queue_op(OP_MUL, KIND_PINF,  '1,       KIND_FIN,   '0,       1'b0);  // inf * 0
		queue_op(OP_MUL, KIND_FIN,   '0,       KIND_NINF,  '0,       1'b0);  // 0 * inf
		queue_op(OP_MUL, KIND_NINF,  '0,       KIND_FIN,   -3,       1'b0);
		queue_op(OP_MUL, KIND_PINF,  '0,       KIND_NINF,  '0,       1'b0);
		queue_op(OP_MUL, KIND_FIN,   VAL_MAX,  KIND_FIN,   VAL_MAX,  1'b0);
		queue_op(OP_DIV, KIND_FIN,   VAL_MIN,  KIND_FIN,   '1,       1'b0);  // MIN / -1 = MIN
		queue_op(OP_DIV, KIND_FIN,   '0,       KIND_FIN,   '0,       1'b0);  // 0 / 0
		queue_op(OP_DIV, KIND_FIN,   -7,       KIND_FIN,   '0,       1'b0);  // minus infinity
		queue_op(OP_DIV, KIND_FIN,   VAL_MAX,  KIND_FIN,   '0,       1'b0);  // plus infinity
		queue_op(OP_DIV, KIND_PINF,  '0,       KIND_FIN,   '0,       1'b0);  // inf / 0 keeps sign
		queue_op(OP_DIV, KIND_NINF,  '0,       KIND_FIN,   -5,       1'b0);  // sign flips
		queue_op(OP_DIV, KIND_PINF,  '0,       KIND_NINF,  '0,       1'b0);  // inf / inf
		queue_op(OP_DIV, KIND_FIN,   -7,       KIND_FIN,   2,        1'b0);  // truncates to -3
		queue_op(OP_DIV, KIND_FIN,   9,        KIND_PINF,  '0,       1'b0);  // finite / inf = 0

		// random part; the sender pauses for a full drain twice along the way
		for (int i = 0; i < RANDOM_OPS; i++)
			queue_op(op_t'($urandom_range(0, 3)), rand_kind(), rand_value(),
			         rand_kind(), rand_value(), (i == 0 || i == RANDOM_OPS / 2));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// wait for everything to go in and come back, then let the pipe settle
		while (pending_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_cnt == 0)
			$display("extended_integer_alu_tb OK");
		else
			$display("extended_integer_alu_tb NOT OK");
		$finish;
	end

endmodule
